@@ src/tile_layer_line_fetch_defines.svh @@
// Assertion macros for the tile layer line fetch block.
`ifndef TILE_LAYER_LINE_FETCH_DEFINES_SVH
`define TILE_LAYER_LINE_FETCH_DEFINES_SVH

`ifndef SYNTHESIS

// Check a consequence in the same cycle as its cause
`define TLLF_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tllf: same-cycle check failed");

// Check a consequence in the cycle after its cause
`define TLLF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tllf: next-cycle check failed");

`else

`define TLLF_ASSERT_SAME(name, ante, cons)
`define TLLF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ src/tllf_pkg.sv @@
// Shared types and constants of the tile layer line fetch block.
package tllf_pkg;

  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = 13;

  // Item kinds
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Layer select
  localparam logic LAYER_WINDOW = 1'b0;
  localparam logic LAYER_BG     = 1'b1;

  // Control byte bits
  localparam int LCD_BG_MAP_BIT  = 3;
  localparam int LCD_TILE_SET_BIT = 4;
  localparam int LCD_WIN_MAP_BIT = 6;

  // Tile maps sit at offsets 0x1800 / 0x1C00 of the store
  localparam logic [1:0] MAP_AREA = 2'b11;

  // Window placement: column is window_x minus eight
  localparam logic [8:0] WIN_X_LO = 9'd8;
  localparam logic [8:0] WIN_X_HI = 9'd264;
  localparam logic [7:0] WIN_X_SHIFT = 8'd8;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CONTROL    = 3'd0;
  localparam logic [2:0] REG_VSCROLL    = 3'd1;
  localparam logic [2:0] REG_HSCROLL    = 3'd2;
  localparam logic [2:0] REG_WINDOW_Y   = 3'd3;
  localparam logic [2:0] REG_WINDOW_X   = 3'd4;
  localparam logic [2:0] REG_BG_PALETTE = 3'd5;

  typedef struct packed {
    logic               op;
    logic [VRAM_AW-1:0] mem_address;
    logic [7:0]         mem_data;
    logic [7:0]         scanline;
    logic [4:0]         tile_column;
    logic               layer;
  } item_t;

  // One fetched tile line, handed from the fetch unit to the emitter
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [4:0] tile_column;
    logic [7:0] scanline;
    logic       layer;
  } line_t;

  typedef struct packed {
    logic [7:0] hscroll;
    logic [7:0] window_y;
    logic [7:0] window_x;
    logic [7:0] bg_palette;
  } cfg_t;

  typedef struct packed {
    logic       last;
    logic       in_range;
    logic [1:0] shade;
    logic [1:0] color_index;
    logic [7:0] pixel_y;
    logic [7:0] pixel_x;
  } pixel_t;

endpackage

@@ src/tllf_fetch.sv @@
// Video memory and the three-read tile line fetch sequencer.
module tllf_fetch (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tllf_pkg::item_t in_item,
  input  logic [7:0]     ctrl,
  input  logic [7:0]     vscroll,
  output logic           line_valid,
  input  logic           line_ready,
  output tllf_pkg::line_t line
);
  import tllf_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MAP  = 2'd1;
  localparam logic [1:0] F_LO   = 2'd2;
  localparam logic [1:0] F_HI   = 2'd3;

  logic [7:0]         mem [VRAM_DEPTH];
  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [7:0]         rd_data;
  logic               rd_en;
  logic [VRAM_AW-1:0] rd_addr;
  logic [VRAM_AW-1:0] map_addr;
  logic [VRAM_AW-1:0] tile_addr;
  logic [VRAM_AW-2:0] tile_base;
  logic [4:0]         col;
  logic [7:0]         scan;
  logic               layer;
  logic [2:0]         tline;
  logic [7:0]         lo;
  logic [7:0]         ysum;
  logic               map_sel;
  logic               accept;
  logic               is_render;
  logic               is_write;

  // Take a new item when idle or when the finished line leaves
  assign in_ready   = (state == F_IDLE) || ((state == F_HI) && line_ready);
  assign line_valid = (state == F_HI);
  assign accept     = in_valid && in_ready;
  assign is_render  = accept && (in_item.op == OP_RENDER);
  assign is_write   = accept && (in_item.op == OP_WRITE);

  // Map row: background scrolls and wraps, window uses the line as given
  assign ysum    = (in_item.layer == LAYER_BG) ? (in_item.scanline + vscroll)
                                               : in_item.scanline;
  assign map_sel = (in_item.layer == LAYER_BG) ? ctrl[LCD_BG_MAP_BIT]
                                               : ctrl[LCD_WIN_MAP_BIT];
  assign map_addr = {MAP_AREA, map_sel, ysum[7:3], in_item.tile_column};

  // Tile line address: the set at 0x1000 of the store takes a signed tile number
  assign tile_addr = {~ctrl[LCD_TILE_SET_BIT] & ~rd_data[7], rd_data, tline, 1'b0};

  // Pick the read of each step
  always_comb begin
    unique case (state)
      F_MAP: begin
        rd_en   = 1'b1;
        rd_addr = tile_addr;
      end
      F_LO: begin
        rd_en   = 1'b1;
        rd_addr = {tile_base, 1'b1};
      end
      default: begin
        rd_en   = is_render;
        rd_addr = map_addr;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    unique case (state)
      F_IDLE:  state_next = is_render ? F_MAP : F_IDLE;
      F_MAP:   state_next = F_LO;
      F_LO:    state_next = F_HI;
      F_HI:    state_next = line_ready ? (is_render ? F_MAP : F_IDLE) : F_HI;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[in_item.mem_address] <= in_item.mem_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold the item fields and partial results
  always_ff @(posedge clk) begin
    if (is_render) begin
      col   <= in_item.tile_column;
      scan  <= in_item.scanline;
      layer <= in_item.layer;
      tline <= ysum[2:0];
    end
    if (state == F_MAP) begin
      tile_base <= tile_addr[VRAM_AW-1:1];
    end
    if (state == F_LO) begin
      lo <= rd_data;
    end
  end

  assign line.lo          = lo;
  assign line.hi          = rd_data;
  assign line.tile_column = col;
  assign line.scanline    = scan;
  assign line.layer       = layer;

endmodule

@@ src/tllf_emit.sv @@
// Line buffer and eight-pixel emitter with position and palette mapping.
module tllf_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             line_valid,
  output logic             line_ready,
  input  tllf_pkg::line_t  line,
  input  tllf_pkg::cfg_t   cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output tllf_pkg::pixel_t pixel
);
  import tllf_pkg::*;

  logic       buf_valid;
  line_t      buf_line;
  logic       busy;
  line_t      cur;
  logic [2:0] cnt;
  logic       done;
  logic       take;
  logic       load;
  logic [2:0] off;
  logic [7:0] xcol;
  logic [8:0] sx;
  logic [8:0] sy;
  logic [1:0] ci;

  assign line_ready = !buf_valid;
  assign load       = line_valid && line_ready;
  assign done       = busy && out_ready && (cnt == 3'd7);
  assign take       = !busy || done;
  assign out_valid  = busy;

  // Hold one fetched line while the current one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      busy      <= 1'b0;
      cnt       <= 3'd0;
    end else begin
      if (take) begin
        busy <= buf_valid;
        cnt  <= 3'd0;
      end else if (out_ready) begin
        cnt <= cnt + 3'd1;
      end
      if (load) begin
        buf_valid <= 1'b1;
      end else if (take) begin
        buf_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_line <= line;
    end
    if (take && buf_valid) begin
      cur <= buf_line;
    end
  end

  // Rightmost pixel first: column offset is seven minus the count
  assign off  = ~cnt;
  assign xcol = {cur.tile_column, off};
  assign sx   = {1'b0, xcol} + {1'b0, cfg.window_x};
  assign sy   = {1'b0, cur.scanline} + {1'b0, cfg.window_y};
  assign ci   = {cur.hi[cnt], cur.lo[cnt]};

  // Place the pixel and map the color through the palette
  always_comb begin
    pixel.color_index = ci;
    pixel.last        = (cnt == 3'd7);
    unique case (ci)
      2'd0: pixel.shade = cfg.bg_palette[1:0];
      2'd1: pixel.shade = cfg.bg_palette[3:2];
      2'd2: pixel.shade = cfg.bg_palette[5:4];
      2'd3: pixel.shade = cfg.bg_palette[7:6];
      default: pixel.shade = cfg.bg_palette[1:0];
    endcase
    if (cur.layer == LAYER_BG) begin
      pixel.pixel_x  = xcol - cfg.hscroll;
      pixel.pixel_y  = cur.scanline;
      pixel.in_range = 1'b1;
    end else begin
      pixel.pixel_x  = sx[7:0] - WIN_X_SHIFT;
      pixel.pixel_y  = sy[7:0];
      pixel.in_range = (sx >= WIN_X_LO) && (sx < WIN_X_HI) && !sy[8];
    end
  end

endmodule

@@ src/tile_layer_line_fetch.sv @@
// Top level: configuration registers, stream ports, fetch unit and emitter.
//
//  channel   dir  kind          payload
//  s_axis    in   stream        op (tuser), write and render fields (tdata)
//  m_axis    out  stream        eight pixels per render item, tlast on the eighth
//  apb       in   config port   six 8-bit registers at 4*i
//
// A render item takes three reads of the video memory (tile map, low plane,
// high plane): the map read as it is accepted, then the plane reads in F_MAP
// and F_LO; the line is offered in F_HI. The emitter, sending eight pixels
// per render item, limits the sustained rate. Write items emit nothing.
// Reset clears the registers and control state; memory contents stay
// undefined until written. A stalled output holds the current pixel, one
// further line waits in a buffer, and input ready drops behind it.
`include "tile_layer_line_fetch_defines.svh"

module tile_layer_line_fetch (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mem_address[12:0], mem_data[20:13], scanline[28:21], tile_column[33:29],
  // layer[34], zero fill [39:35]
  input  logic [39:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[7:0], pixel_y[15:8], color_index[17:16], shade[19:18],
  // in_range[20], zero fill [23:21]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tllf_pkg::*;

  logic [7:0] ctrl;
  logic [7:0] vscroll;
  logic [7:0] hscroll;
  logic [7:0] window_y;
  logic [7:0] window_x;
  logic [7:0] bg_palette;
  logic       cfg_write;
  logic [2:0] reg_index;
  item_t      item;
  line_t      line_bus;
  logic       line_valid;
  logic       line_ready;
  cfg_t       cfg;
  pixel_t     pixel;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= 8'd0;
      vscroll    <= 8'd0;
      hscroll    <= 8'd0;
      window_y   <= 8'd0;
      window_x   <= 8'd0;
      bg_palette <= 8'd0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_CONTROL:    ctrl       <= pwdata[7:0];
        REG_VSCROLL:    vscroll    <= pwdata[7:0];
        REG_HSCROLL:    hscroll    <= pwdata[7:0];
        REG_WINDOW_Y:   window_y   <= pwdata[7:0];
        REG_WINDOW_X:   window_x   <= pwdata[7:0];
        REG_BG_PALETTE: bg_palette <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the configuration registers
  always_comb begin
    unique case (reg_index)
      REG_CONTROL:    prdata = {24'd0, ctrl};
      REG_VSCROLL:    prdata = {24'd0, vscroll};
      REG_HSCROLL:    prdata = {24'd0, hscroll};
      REG_WINDOW_Y:   prdata = {24'd0, window_y};
      REG_WINDOW_X:   prdata = {24'd0, window_x};
      REG_BG_PALETTE: prdata = {24'd0, bg_palette};
      default:        prdata = 32'd0;
    endcase
  end

  // Unpack the input item
  assign item.op          = s_axis_tuser[0];
  assign item.mem_address = s_axis_tdata[12:0];
  assign item.mem_data    = s_axis_tdata[20:13];
  assign item.scanline    = s_axis_tdata[28:21];
  assign item.tile_column = s_axis_tdata[33:29];
  assign item.layer       = s_axis_tdata[34];

  assign cfg.hscroll    = hscroll;
  assign cfg.window_y   = window_y;
  assign cfg.window_x   = window_x;
  assign cfg.bg_palette = bg_palette;

  tllf_fetch u_fetch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (item),
    .ctrl       (ctrl),
    .vscroll    (vscroll),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line       (line_bus)
  );

  tllf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line       (line_bus),
    .cfg        (cfg),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .pixel      (pixel)
  );

  // Pack the output pixel
  assign m_axis_tdata = {3'd0, pixel.in_range, pixel.shade, pixel.color_index,
                         pixel.pixel_y, pixel.pixel_x};
  assign m_axis_tlast = pixel.last;

  // A render item keeps the fetch unit busy for its map read
  `TLLF_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready && item.op == OP_RENDER, !s_axis_tready)
  // A fetched line waits unchanged until the buffer takes it
  `TLLF_ASSERT_NEXT(a_line_hold, line_valid && !line_ready, line_valid && $stable(line_bus))
  // A run does not end before its eighth pixel
  `TLLF_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)
  // Input is taken only when the fetch unit has room for its line
  `TLLF_ASSERT_SAME(a_ready_room, s_axis_tready && line_valid, line_ready)

endmodule

@@ verif/tllf_pixel_checker.sv @@
// Pixel checker: mirrors video memory and registers, predicts each tile line, compares.
`timescale 1ns / 1ps

module tllf_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          renders_seen,
  output int          writes_seen,
  output int          pixels_seen,
  output int          clipped_seen
);
  import tllf_pkg::*;

  logic [7:0] vram [VRAM_DEPTH];
  logic [7:0] ctrl, vscroll, hscroll, window_y, window_x, bg_palette;
  pixel_t     pixels_due [$];

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: pixel %0d %s: got %0d, expected %0d",
               $time, pixels_seen, what, got_v, want_v);
  endtask

  // Work out the eight pixels of one tile line, rightmost first
  task automatic predict_tile_line(input logic [7:0] line, input logic [4:0] col,
                                   input logic layer);
    logic        bg;
    logic [12:0] map_at, tile_at;
    logic [8:0]  y, wy_pos;
    logic [9:0]  wx_pos;
    logic [7:0]  tnum, lo, hi, off;
    logic [1:0]  ci;
    pixel_t      px;
    bg = (layer == LAYER_BG);
    map_at = ctrl[bg ? LCD_BG_MAP_BIT : LCD_WIN_MAP_BIT] ? 13'h1c00 : 13'h1800;
    y = bg ? {1'b0, line} + {1'b0, vscroll} : {1'b0, line};
    map_at = map_at + {3'b000, y[7:3], col};
    tnum = vram[map_at];
    // Unsigned set at the base of the store, signed set around its middle
    if (ctrl[LCD_TILE_SET_BIT])
      tile_at = {1'b0, tnum, 4'b0000};
    else
      tile_at = 13'h1000 + {tnum[7], tnum, 4'b0000};
    tile_at = tile_at + {9'd0, y[2:0], 1'b0};
    lo = vram[tile_at];
    hi = vram[tile_at + 13'd1];
    for (int k = 0; k < 8; k++) begin
      ci = {hi[k], lo[k]};
      off = 8'd7 - 8'(k);
      px.color_index = ci;
      px.shade = bg_palette[2*ci +: 2];
      px.last = (k == 7);
      if (bg) begin
        px.pixel_x = {col, 3'b000} + off - hscroll;
        px.pixel_y = line;
        px.in_range = 1'b1;
      end else begin
        wx_pos = {2'b00, col, 3'b000} + {2'b00, off} + {2'b00, window_x};
        wy_pos = {1'b0, line} + {1'b0, window_y};
        px.in_range = (wx_pos >= 10'(WIN_X_LO)) && (wx_pos < 10'(WIN_X_HI)) && !wy_pos[8];
        px.pixel_x = wx_pos[7:0] - WIN_X_SHIFT;
        px.pixel_y = wy_pos[7:0];
      end
      pixels_due = {pixels_due, px};
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      ctrl = '0;
      vscroll = '0;
      hscroll = '0;
      window_y = '0;
      window_x = '0;
      bg_palette = '0;
      pixels_due.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CONTROL:    ctrl = pwdata[7:0];
          REG_VSCROLL:    vscroll = pwdata[7:0];
          REG_HSCROLL:    hscroll = pwdata[7:0];
          REG_WINDOW_Y:   window_y = pwdata[7:0];
          REG_WINDOW_X:   window_x = pwdata[7:0];
          REG_BG_PALETTE: bg_palette = pwdata[7:0];
          default: ;
        endcase
      end
      // Store written bytes, predict rendered lines
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == OP_WRITE) begin
          vram[s_axis_tdata[12:0]] = s_axis_tdata[20:13];
          writes_seen++;
        end else begin
          predict_tile_line(s_axis_tdata[28:21], s_axis_tdata[33:29], s_axis_tdata[34]);
          renders_seen++;
        end
      end
      // Compare each output pixel with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = pixel_t'({m_axis_tlast, m_axis_tdata[20:0]});
        pixels_seen++;
        if (pixels_due.size() == 0) begin
          report_mismatch("pixel with no line pending", int'(got), 0);
        end else begin
          want = pixels_due.pop_front();
          if (!want.in_range) clipped_seen++;
          if (got.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", int'(got.pixel_x), int'(want.pixel_x));
          if (got.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", int'(got.pixel_y), int'(want.pixel_y));
          if (got.color_index !== want.color_index)
            report_mismatch("color_index", int'(got.color_index), int'(want.color_index));
          if (got.shade !== want.shade)
            report_mismatch("shade", int'(got.shade), int'(want.shade));
          if (got.in_range !== want.in_range)
            report_mismatch("in_range", int'(got.in_range), int'(want.in_range));
          if (got.last !== want.last)
            report_mismatch("last", int'(got.last), int'(want.last));
        end
      end
    end
    pending = pixels_due.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top: clock, reset, stimulus for memory writes and tile line renders, verdict.
`timescale 1ns / 1ps

module tb;
  import tllf_pkg::*;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [23:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int mismatches, pending, renders_seen, writes_seen, pixels_seen, clipped_seen;

  // Shadow of the store, used only to keep renders on written bytes
  logic [7:0] shadow [VRAM_DEPTH];
  bit         stored [VRAM_DEPTH];
  logic [7:0] reg_copy [6];
  int         items_sent;
  int         settings_run;
  bit         calm_phase;

  tile_layer_line_fetch dut (.*);

  tllf_pixel_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (calm_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [7:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 50) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [12:0] map_offset(input logic [7:0] line, input logic [4:0] col,
                                             input logic layer);
    logic [7:0] y;
    logic       upper;
    y = (layer == LAYER_BG) ? line + reg_copy[REG_VSCROLL] : line;
    upper = reg_copy[REG_CONTROL][(layer == LAYER_BG) ? LCD_BG_MAP_BIT : LCD_WIN_MAP_BIT];
    return {MAP_AREA, upper, y[7:3], col};
  endfunction

  // Offer one item, hold it until taken, then idle a while
  task automatic send_item(input logic op, input logic [12:0] addr, input logic [7:0] data,
                           input logic [7:0] line, input logic [4:0] col, input logic layer);
    s_axis_tuser = op;
    s_axis_tdata = {5'b00000, layer, col, line, data, addr};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    items_sent++;
    if (op == OP_WRITE) begin
      shadow[addr] = data;
      stored[addr] = 1'b1;
    end
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic put_byte(input logic [12:0] addr, input logic [7:0] data);
    send_item(OP_WRITE, addr, data, 8'($urandom), 5'($urandom), 1'($urandom));
  endtask

  task automatic ensure_byte(input logic [12:0] addr);
    if (!stored[addr]) put_byte(addr, 8'($urandom));
  endtask

  task automatic put_map(input logic [7:0] line, input logic [4:0] col, input logic layer,
                         input logic [7:0] tnum);
    put_byte(map_offset(line, col, layer), tnum);
  endtask

  // Render one tile line, first filling any byte it reads that was never written
  task automatic render(input logic [7:0] line, input logic [4:0] col, input logic layer);
    logic [12:0] m, t;
    logic [7:0]  y, tnum;
    m = map_offset(line, col, layer);
    ensure_byte(m);
    tnum = shadow[m];
    y = (layer == LAYER_BG) ? line + reg_copy[REG_VSCROLL] : line;
    t = reg_copy[REG_CONTROL][LCD_TILE_SET_BIT] ? {1'b0, tnum, 4'b0000}
                                                : {~tnum[7], tnum, 4'b0000};
    t = t | {9'd0, y[2:0], 1'b0};
    ensure_byte(t);
    ensure_byte(t + 13'd1);
    send_item(OP_RENDER, 13'($urandom), 8'($urandom), line, col, layer);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {24'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    reg_copy[idx] = val;
  endtask

  // Drain the block, then let a write still in flight settle
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] lcd, input logic [7:0] sy, input logic [7:0] sx,
                           input logic [7:0] wy, input logic [7:0] wx, input logic [7:0] pal);
    wait_idle();
    write_reg(REG_CONTROL, lcd);
    write_reg(REG_VSCROLL, sy);
    write_reg(REG_HSCROLL, sx);
    write_reg(REG_WINDOW_Y, wy);
    write_reg(REG_WINDOW_X, wx);
    write_reg(REG_BG_PALETTE, pal);
    settings_run++;
  endtask

  // Receiver: ready bursts with short and long gaps, plus two long hold-offs
  initial begin : sink
    int run, gap, r, holds;
    holds = 0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (holds < 2 && pixels_seen >= 250 + 450 * holds) begin
        m_axis_tready = 1'b0;
        holds++;
        repeat (300) @(negedge clk);
      end
      run = ($urandom_range(99) < 10) ? 150 : $urandom_range(24, 1);
      m_axis_tready = 1'b1;
      repeat (run) @(negedge clk);
      r = $urandom_range(99);
      gap = (r < 70) ? 1 : (r < 90) ? $urandom_range(4, 2) : $urandom_range(40, 10);
      m_axis_tready = 1'b0;
      repeat (gap) @(negedge clk);
    end
  end

  initial begin : stimulus
    int goal, r;
    logic [7:0] line;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    settings_run = 0;
    calm_phase = 1'b0;
    foreach (reg_copy[i]) reg_copy[i] = 8'h00;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: full scrolls, window off left, right, bottom edges, signed and unsigned sets
    configure(8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'he4);
    put_map(8'd0, 5'd0, LAYER_BG, 8'h80);
    render(8'd0, 5'd0, LAYER_BG);
    put_map(8'd143, 5'd31, LAYER_WINDOW, 8'h7f);
    render(8'd143, 5'd31, LAYER_WINDOW);
    put_map(8'd0, 5'd0, LAYER_WINDOW, 8'hff);
    render(8'd0, 5'd0, LAYER_WINDOW);
    render(8'd255, 5'd17, LAYER_BG);
    put_byte(13'h1fff, 8'hff);
    put_byte(13'h0000, 8'h00);
    configure(8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h1b);
    put_map(8'd0, 5'd31, LAYER_BG, 8'hff);
    render(8'd0, 5'd31, LAYER_BG);
    put_map(8'd255, 5'd0, LAYER_WINDOW, 8'h00);
    render(8'd255, 5'd0, LAYER_WINDOW);
    render(8'd100, 5'd31, LAYER_WINDOW);

    // Random phases, each under a fresh register setting
    goal = items_sent;
    for (int p = 0; p < 6; p++) begin
      configure(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      calm_phase = (p % 3 == 2);
      goal += 51;
      while (items_sent < goal) begin
        r = $urandom_range(99);
        if (r < 55) begin
          line = ($urandom_range(99) < 80) ? 8'($urandom_range(143))
                                           : 8'($urandom_range(255, 144));
          render(line, 5'($urandom), 1'($urandom));
        end else if (r < 75) begin
          put_byte(13'h1800 + 13'($urandom_range(2047)), 8'($urandom));
        end else if (r < 95) begin
          put_byte(13'($urandom_range(13'h17ff)), 8'($urandom));
        end else begin
          put_byte(13'($urandom), 8'($urandom));
        end
      end
    end
    calm_phase = 1'b0;

    // Drain and give a stray pixel time to show up
    while (pending != 0) @(negedge clk);
    repeat (32) @(negedge clk);
    $display("Covered %0d tile line renders (%0d pixels, %0d outside the map), %0d byte writes",
             renders_seen, pixels_seen, clipped_seen, writes_seen);
    $display("over %0d register settings, with stalls on both streams", settings_run);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ tile_layer_line_fetch.f @@
+incdir+src
src/tllf_pkg.sv
src/tllf_fetch.sv
src/tllf_emit.sv
src/tile_layer_line_fetch.sv
verif/tllf_pixel_checker.sv
verif/tb.sv
